FILE: rtl/qpn_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the normalized quaternion product block.
// No dependencies.
package qpn_pkg;

    localparam int COMPONENT_WIDTH_DEFAULT = 16;
    // Result format: signed Q1.14 in a 16-bit field.
    localparam int OUT_FRAC    = 14;
    localparam int OUT_WIDTH   = 16;
    // Bits of the doubled quotient floor(2 * |p_i| * 2^14 / |p|).
    localparam int ROOT_WIDTH  = OUT_FRAC + 2;
    // Queue between front and back; its depth is also the input credit limit.
    localparam int QUEUE_DEPTH = 8;
    localparam int FRONT_STAGES = 4;

endpackage

FILE: rtl/qpn_front.sv
`timescale 1ns / 1ps
// Front end: Hamilton product, magnitudes, squares and the squared norm.
// Depends on qpn_pkg. Four register stages, one beat per cycle, no stall.
module qpn_front
    import qpn_pkg::*;
#(
    parameter int CW = COMPONENT_WIDTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic signed [CW-1:0]   first_w,
    input  logic signed [CW-1:0]   first_x,
    input  logic signed [CW-1:0]   first_y,
    input  logic signed [CW-1:0]   first_z,
    input  logic signed [CW-1:0]   second_w,
    input  logic signed [CW-1:0]   second_x,
    input  logic signed [CW-1:0]   second_y,
    input  logic signed [CW-1:0]   second_z,
    output logic                   push,
    output logic [3:0]             neg,
    output logic [4*(4*CW+2)-1:0]  msq,
    output logic [4*CW+3:0]        sumsq
);

    localparam int PW = 2 * CW + 2;
    localparam int MW = 2 * CW + 1;
    localparam int QW = 2 * MW;
    localparam int SW = QW + 2;

    logic [FRONT_STAGES-1:0] v_reg;
    logic signed [2*CW-1:0]  prod_reg [16];
    logic signed [PW-1:0]    p_reg [4];
    logic [QW-1:0]           sq_reg [4];
    logic [3:0]              neg_reg;
    logic [3:0]              neg2_reg;
    logic [SW-1:0]           s_reg;
    logic [QW-1:0]           sq2_reg [4];
    logic [MW-1:0]           mag [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[FRONT_STAGES-2:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg[0]  <= first_w * second_w;
        prod_reg[1]  <= first_x * second_x;
        prod_reg[2]  <= first_y * second_y;
        prod_reg[3]  <= first_z * second_z;
        prod_reg[4]  <= first_w * second_x;
        prod_reg[5]  <= first_x * second_w;
        prod_reg[6]  <= first_y * second_z;
        prod_reg[7]  <= first_z * second_y;
        prod_reg[8]  <= first_w * second_y;
        prod_reg[9]  <= first_x * second_z;
        prod_reg[10] <= first_y * second_w;
        prod_reg[11] <= first_z * second_x;
        prod_reg[12] <= first_w * second_z;
        prod_reg[13] <= first_x * second_y;
        prod_reg[14] <= first_y * second_x;
        prod_reg[15] <= first_z * second_w;
    end

    always_ff @(posedge clk)
    begin
        p_reg[0] <= PW'(prod_reg[0]) - PW'(prod_reg[1]) - PW'(prod_reg[2])
                    - PW'(prod_reg[3]);
        p_reg[1] <= PW'(prod_reg[4]) + PW'(prod_reg[5]) + PW'(prod_reg[6])
                    - PW'(prod_reg[7]);
        p_reg[2] <= PW'(prod_reg[8]) - PW'(prod_reg[9]) + PW'(prod_reg[10])
                    + PW'(prod_reg[11]);
        p_reg[3] <= PW'(prod_reg[12]) + PW'(prod_reg[13]) - PW'(prod_reg[14])
                    + PW'(prod_reg[15]);
    end

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            mag[l] = p_reg[l][PW-1] ? MW'(-p_reg[l]) : MW'(p_reg[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 4; l++)
        begin
            sq_reg[l]  <= mag[l] * mag[l];
            neg_reg[l] <= p_reg[l][PW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]) + SW'(sq_reg[3]);
        for (int l = 0; l < 4; l++)
        begin
            sq2_reg[l] <= sq_reg[l];
        end
        neg2_reg <= neg_reg;
    end

    assign push  = v_reg[FRONT_STAGES-1];
    assign neg   = neg2_reg;
    assign msq   = {sq2_reg[3], sq2_reg[2], sq2_reg[1], sq2_reg[0]};
    assign sumsq = s_reg;

endmodule

FILE: rtl/qpn_queue.sv
`timescale 1ns / 1ps
// Short FIFO between front and back ends.
// Depends on qpn_pkg for its depth.
module qpn_queue
    import qpn_pkg::*;
#(
    parameter int DW = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] wdata,
    input  logic          pop,
    output logic          nonempty,
    output logic [DW-1:0] rdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    logic [DW-1:0]   mem [QUEUE_DEPTH];
    logic [AW-1:0]   wr_reg;
    logic [AW-1:0]   rd_reg;
    logic [CNTW-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + CNTW'(push) - CNTW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= wdata;
        end
    end

    assign nonempty = (cnt_reg != '0);
    assign rdata    = mem[rd_reg];

endmodule

FILE: rtl/qpn_back.sv
`timescale 1ns / 1ps
// Back end: per-lane bit-serial root/quotient pipeline and final rounding.
// Depends on qpn_pkg. Whole pipeline advances when the output register frees.
module qpn_back
    import qpn_pkg::*;
#(
    parameter int CW = COMPONENT_WIDTH_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  logic [3:0]                    q_neg,
    input  logic [4*(4*CW+2)-1:0]         q_msq,
    input  logic [4*CW+3:0]               q_sumsq,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [OUT_WIDTH-1:0]   result_w,
    output logic signed [OUT_WIDTH-1:0]   result_x,
    output logic signed [OUT_WIDTH-1:0]   result_y,
    output logic signed [OUT_WIDTH-1:0]   result_z,
    output logic                          zero_norm
);

    localparam int QW = 4 * CW + 2;
    localparam int SW = QW + 2;
    localparam int NSTEP = ROOT_WIDTH;
    localparam int WW = 4 * CW + 2 * OUT_FRAC + 6;

    // Y = floor(sqrt(msq * 2^30 / s)); R = msq*2^30 - s*Y^2, T = s*Y.
    logic                  v_reg [NSTEP+1];
    logic [WW-1:0]         r_reg [NSTEP+1][4];
    logic [WW-1:0]         t_reg [NSTEP+1][4];
    logic [NSTEP-1:0]      y_reg [NSTEP+1][4];
    logic [SW-1:0]         s_reg [NSTEP+1];
    logic [3:0]            neg_reg [NSTEP+1];
    logic                  en;
    logic                  out_valid_reg;
    logic signed [OUT_WIDTH-1:0] res_reg [4];
    logic                  zero_reg;
    logic [OUT_WIDTH-1:0]  half [4];

    assign en  = !out_valid_reg || !out_stall;
    assign pop = en && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 4; l++)
            begin
                r_reg[0][l] <= WW'(q_msq[l*QW +: QW]) << (2 * OUT_FRAC + 2);
                t_reg[0][l] <= '0;
                y_reg[0][l] <= '0;
            end
            s_reg[0]   <= q_sumsq;
            neg_reg[0] <= q_neg;
        end
    end

    for (genvar j = 1; j <= NSTEP; j++)
    begin : g_step
        localparam int K = NSTEP - j;
        logic [WW-1:0] cand [4];
        logic [WW-1:0] sk;
        logic [WW-1:0] s2k;

        always_comb
        begin
            sk  = WW'(s_reg[j-1]) << K;
            s2k = WW'(s_reg[j-1]) << (2 * K);
            for (int l = 0; l < 4; l++)
            begin
                cand[l] = (t_reg[j-1][l] << (K + 1)) + s2k;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= v_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 4; l++)
                begin
                    if (r_reg[j-1][l] >= cand[l])
                    begin
                        r_reg[j][l] <= r_reg[j-1][l] - cand[l];
                        t_reg[j][l] <= t_reg[j-1][l] + sk;
                        y_reg[j][l] <= y_reg[j-1][l] | (NSTEP'(1) << K);
                    end
                    else
                    begin
                        r_reg[j][l] <= r_reg[j-1][l];
                        t_reg[j][l] <= t_reg[j-1][l];
                        y_reg[j][l] <= y_reg[j-1][l];
                    end
                end
                s_reg[j]   <= s_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
            end
        end
    end

    // Round to nearest: r = (Y + 1) / 2, sign applied afterwards.
    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            half[l] = OUT_WIDTH'(({1'b0, y_reg[NSTEP][l]} + (NSTEP+1)'(1)) >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v_reg[NSTEP];
        end
    end

    // zero norm: the root search saturates to all ones, so force zeros
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 4; l++)
            begin
                if (s_reg[NSTEP] == '0)
                begin
                    res_reg[l] <= '0;
                end
                else if (neg_reg[NSTEP][l])
                begin
                    res_reg[l] <= -$signed(half[l]);
                end
                else
                begin
                    res_reg[l] <= $signed(half[l]);
                end
            end
            zero_reg <= (s_reg[NSTEP] == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign result_w  = res_reg[0];
    assign result_x  = res_reg[1];
    assign result_y  = res_reg[2];
    assign result_z  = res_reg[3];
    assign zero_norm = zero_reg;

    a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_norm |-> result_w == '0 && result_x == '0
                                   && result_y == '0 && result_z == '0)
        else $error("zero norm beat with nonzero components");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result_w <= 16'sd16384 && result_w >= -16'sd16384)
        else $error("result_w outside unit range");

    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

FILE: rtl/quaternion_product_normalize.sv
`timescale 1ns / 1ps
// Normalized Hamilton product: result = (a*b)/|a*b| in signed Q1.14, one beat
// per cycle sustained while the output is not stalled. A beat passes through
// the front end (products, sums, squares, squared norm), is written into the
// queue, then passes through the back end (operand load, 16 restoring
// root/quotient steps, and rounding into the output register). An 8-entry
// queue with credit count lets the input side keep running for up to 8 beats
// while the output is stalled.
// Depends on qpn_pkg.
module quaternion_product_normalize
    import qpn_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [COMPONENT_WIDTH-1:0]  first_w,
    input  logic signed [COMPONENT_WIDTH-1:0]  first_x,
    input  logic signed [COMPONENT_WIDTH-1:0]  first_y,
    input  logic signed [COMPONENT_WIDTH-1:0]  first_z,
    input  logic signed [COMPONENT_WIDTH-1:0]  second_w,
    input  logic signed [COMPONENT_WIDTH-1:0]  second_x,
    input  logic signed [COMPONENT_WIDTH-1:0]  second_y,
    input  logic signed [COMPONENT_WIDTH-1:0]  second_z,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [OUT_WIDTH-1:0]        result_w,
    output logic signed [OUT_WIDTH-1:0]        result_x,
    output logic signed [OUT_WIDTH-1:0]        result_y,
    output logic signed [OUT_WIDTH-1:0]        result_z,
    output logic                               zero_norm
);

    localparam int CW = COMPONENT_WIDTH;
    localparam int QW = 4 * CW + 2;
    localparam int SW = QW + 2;
    localparam int DW = 4 + 4 * QW + SW;
    localparam int CRW = $clog2(QUEUE_DEPTH + 1);

    logic             accept;
    logic             push;
    logic [3:0]       f_neg;
    logic [4*QW-1:0]  f_msq;
    logic [SW-1:0]    f_s;
    logic             pop;
    logic             q_nonempty;
    logic [DW-1:0]    q_data;
    logic [CRW-1:0]   credit_reg;

    // Credits cover beats in the front pipeline plus beats in the queue.
    assign in_stall = (credit_reg == CRW'(QUEUE_DEPTH));
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_reg + CRW'(accept) - CRW'(pop);
        end
    end

    qpn_front #(.CW(CW)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .first_w  (first_w),
        .first_x  (first_x),
        .first_y  (first_y),
        .first_z  (first_z),
        .second_w (second_w),
        .second_x (second_x),
        .second_y (second_y),
        .second_z (second_z),
        .push     (push),
        .neg      (f_neg),
        .msq      (f_msq),
        .sumsq    (f_s)
    );

    qpn_queue #(.DW(DW)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wdata    ({f_s, f_msq, f_neg}),
        .pop      (pop),
        .nonempty (q_nonempty),
        .rdata    (q_data)
    );

    qpn_back #(.CW(CW)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_nonempty),
        .q_neg     (q_data[3:0]),
        .q_msq     (q_data[4 +: 4*QW]),
        .q_sumsq   (q_data[4 + 4*QW +: SW]),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result_w  (result_w),
        .result_x  (result_x),
        .result_y  (result_y),
        .result_z  (result_z),
        .zero_norm (zero_norm)
    );

endmodule
